FILE: rtl/lsbse_pkg.sv
// Shared types, register map, phase codes and the keyed bit permutation
// for the two-bit LSB stego embed/extract block. No dependencies.
package lsbse_pkg;

	localparam int BYTES_PER_SYMBOL = 4;

	localparam int CFG_AW = 4;
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_KEY    = 2'd1;
	localparam logic [1:0] REG_MARKER = 2'd2;

	localparam logic [23:0] KEY_RESET    = 24'd8035874;
	localparam logic [7:0]  MARKER_RESET = 8'd254;

	localparam logic MODE_EMBED   = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	localparam logic [1:0] PH_START   = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_DONE    = 2'd2;
	localparam logic [1:0] PH_RSV     = 2'd3;

	typedef struct packed {
		logic [BYTES_PER_SYMBOL-1:0][7:0] pix;
		logic [7:0]                       payload;
		logic                             payload_valid;
	} item_t;

	typedef struct packed {
		logic [BYTES_PER_SYMBOL-1:0][7:0] pix_out;
		logic [7:0]                       extracted_byte;
		logic                             payload_taken;
		logic                             extracted_valid;
		logic                             done_res;
	} result_t;

	// coded bit 7-i takes the plain bit that key entry i, key[3*i +: 3], names
	function automatic logic [7:0] encode_byte(input logic [23:0] key, input logic [7:0] plain);
		logic [7:0] coded;
		coded = '0;
		for (int i = 0; i < 8; i++) begin
			coded[7-i] = plain[key[3*i +: 3]];
		end
		return coded;
	endfunction

	// lowest key entry naming a plain bit wins; unnamed bits stay zero
	function automatic logic [7:0] decode_byte(input logic [23:0] key, input logic [7:0] coded);
		logic [7:0] plain;
		logic       found;
		plain = '0;
		for (int b = 0; b < 8; b++) begin
			found = 1'b0;
			for (int i = 0; i < 8; i++) begin
				if (!found && key[3*i +: 3] == 3'(b)) begin
					plain[b] = coded[7-i];
					found = 1'b1;
				end
			end
		end
		return plain;
	endfunction

endpackage

FILE: rtl/lsbse_core.sv
// Per-group embed/extract datapath and phase update.
// Depends on lsbse_pkg.
module lsbse_core
	import lsbse_pkg::*;
(
	input  logic        mode,
	input  logic [23:0] key_map,
	input  logic [7:0]  marker_value,
	input  logic [1:0]  phase,
	input  item_t       item,
	output result_t     res,
	output logic [1:0]  phase_nxt
);

	logic [7:0] enc_src;
	logic [7:0] coded_enc;
	logic [7:0] coded_ext;
	logic [7:0] plain_ext;
	logic       do_embed;

	always_comb begin
		enc_src = (phase == PH_PAYLOAD && item.payload_valid) ? item.payload : marker_value;
	end

	assign coded_enc = encode_byte(key_map, enc_src);
	assign coded_ext = {item.pix[0][1:0], item.pix[1][1:0], item.pix[2][1:0], item.pix[3][1:0]};
	assign plain_ext = decode_byte(key_map, coded_ext);
	assign do_embed  = (mode == MODE_EMBED) && (phase == PH_START || phase == PH_PAYLOAD);

	always_comb begin
		for (int k = 0; k < BYTES_PER_SYMBOL; k++) begin
			if (do_embed) begin
				res.pix_out[k] = {item.pix[k][7:2],
					coded_enc[2*(BYTES_PER_SYMBOL-1-k) +: 2]};
			end else begin
				res.pix_out[k] = item.pix[k];
			end
		end
		res.extracted_byte  = 8'd0;
		res.payload_taken   = 1'b0;
		res.extracted_valid = 1'b0;
		res.done_res        = 1'b0;
		phase_nxt           = phase;
		if (mode == MODE_EMBED) begin
			case (phase)
				PH_START: begin
					phase_nxt = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (item.payload_valid) begin
						res.payload_taken = 1'b1;
					end else begin
						phase_nxt    = PH_DONE;
						res.done_res = 1'b1;
					end
				end
				default: begin
					res.done_res = 1'b1;
				end
			endcase
		end else begin
			res.extracted_byte = plain_ext;
			case (phase)
				PH_START: begin
					if (plain_ext == marker_value) begin
						phase_nxt = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (plain_ext == marker_value) begin
						phase_nxt    = PH_DONE;
						res.done_res = 1'b1;
					end else begin
						res.extracted_valid = 1'b1;
					end
				end
				default: begin
					res.done_res = 1'b1;
				end
			endcase
		end
	end

endmodule

FILE: rtl/lsb_stego_embed_extract.sv
// Two-bit LSB steganography embed/extract top level: stream ports, APB registers.
// An accepted beat goes to the input register, its result to the result register.
// Throughput: one pixel group per cycle while m_tready is high; each register
// holds one beat, so an empty input register takes input while a result waits.
// Reset: registers return to mode embed, key 8035874, marker 254; phase to start.
// Depends on lsbse_pkg and lsbse_core.
module lsb_stego_embed_extract
	import lsbse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// [7:0] pixel_byte_0, [15:8] pixel_byte_1, [23:16] pixel_byte_2,
	// [31:24] pixel_byte_3, [39:32] payload_byte
	input  logic [39:0]       s_tdata,
	// [0] payload_valid
	input  logic              s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// [7:0] pixel_out_0, [15:8] pixel_out_1, [23:16] pixel_out_2,
	// [31:24] pixel_out_3, [39:32] extracted_byte
	output logic [39:0]       m_tdata,
	// [0] payload_taken, [1] extracted_valid, [2] done_res
	output logic [2:0]        m_tuser,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic        mode_q;
	logic [23:0] key_map_q;
	logic [7:0]  marker_q;
	logic [1:0]  phase_q;
	logic [1:0]  phase_nxt;

	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res_c;

	logic        adv_s2;
	logic        adv_s1;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_EMBED;
			key_map_q <= KEY_RESET;
			marker_q  <= MARKER_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MODE:   mode_q    <= pwdata[0];
				REG_KEY:    key_map_q <= pwdata[23:0];
				REG_MARKER: marker_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODE:   prdata = {31'd0, mode_q};
			REG_KEY:    prdata = {8'd0, key_map_q};
			REG_MARKER: prdata = {24'd0, marker_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.pix[0]        <= s_tdata[7:0];
			item_s1.pix[1]        <= s_tdata[15:8];
			item_s1.pix[2]        <= s_tdata[23:16];
			item_s1.pix[3]        <= s_tdata[31:24];
			item_s1.payload       <= s_tdata[39:32];
			item_s1.payload_valid <= s_tuser;
		end
	end

	lsbse_core u_core (
		.mode         (mode_q),
		.key_map      (key_map_q),
		.marker_value (marker_q),
		.phase        (phase_q),
		.item         (item_s1),
		.res          (res_c),
		.phase_nxt    (phase_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				phase_q <= phase_nxt;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.extracted_byte, res_s2.pix_out[3], res_s2.pix_out[2],
		res_s2.pix_out[1], res_s2.pix_out[0]};
	assign m_tuser  = {res_s2.done_res, res_s2.extracted_valid, res_s2.payload_taken};

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_RSV)
		else $error("phase reached unused code");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("phase left done");

	a_done_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> phase_q == PH_DONE)
		else $error("done beat without done phase");

	a_taken_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("embed and extract flags in one beat");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled with room in pipeline");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for lsb_stego_embed_extract: pixel groups go in, and each result
// beat is compared with a built-in embed/extract predictor. Needs lsbse_pkg and the RTL.
module testbench;
	import lsbse_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0]      payload;
		logic [3:0][7:0] pix;
		logic            pvalid;
	} group_t;

	typedef struct packed {
		logic [3:0][7:0] pix;
		logic [7:0]      xbyte;
		logic            taken;
		logic            xvalid;
		logic            done;
	} outcome_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKE} rx_style_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	// [7:0] pixel_byte_0, [15:8] pixel_byte_1, [23:16] pixel_byte_2,
	// [31:24] pixel_byte_3, [39:32] payload_byte
	logic [39:0]       s_tdata;
	// [0] payload_valid
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// [7:0] pixel_out_0, [15:8] pixel_out_1, [23:16] pixel_out_2,
	// [31:24] pixel_out_3, [39:32] extracted_byte
	logic [39:0]       m_tdata;
	// [0] payload_taken, [1] extracted_valid, [2] done_res
	logic [2:0]        m_tuser;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	logic        cfg_mode = MODE_EMBED;
	logic [23:0] cfg_key = KEY_RESET;
	logic [7:0]  cfg_marker = MARKER_RESET;
	logic [1:0]  stego_phase = PH_START;

	outcome_t  expected_results[$];
	int        mismatches = 0;
	int        sent = 0;
	int        cycle_count = 0;
	int        rx_count = 0;
	rx_style_t rx_style = RX_OPEN;

	lsb_stego_embed_extract dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic logic [7:0] scramble(input logic [23:0] key, input logic [7:0] plain);
		logic [7:0] coded;
		for (int pos = 0; pos < 8; pos++)
			coded[7 - pos] = plain[(key >> (3 * pos)) & 24'd7];
		return coded;
	endfunction

	// walk entries downward so the lowest entry naming a bit is applied last
	function automatic logic [7:0] unscramble(input logic [23:0] key, input logic [7:0] coded);
		logic [7:0] plain;
		logic [2:0] src;
		plain = '0;
		for (int pos = 7; pos >= 0; pos--) begin
			src = key[3 * pos +: 3];
			plain[src] = coded[7 - pos];
		end
		return plain;
	endfunction

	function automatic logic [3:0][7:0] stamp(input logic [3:0][7:0] pix, input logic [7:0] coded);
		logic [3:0][7:0] res;
		for (int k = 0; k < 4; k++)
			res[k] = {pix[k][7:2], coded[7 - 2 * k -: 2]};
		return res;
	endfunction

	function automatic logic [7:0] low_bits(input logic [3:0][7:0] pix);
		return {pix[0][1:0], pix[1][1:0], pix[2][1:0], pix[3][1:0]};
	endfunction

	function automatic outcome_t predict_group(input group_t g);
		outcome_t r;
		logic [7:0] plain;
		r = '0;
		r.pix = g.pix;
		if (cfg_mode == MODE_EMBED) begin
			case (stego_phase)
				PH_START: begin
					r.pix = stamp(g.pix, scramble(cfg_key, cfg_marker));
					stego_phase = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (g.pvalid) begin
						r.pix = stamp(g.pix, scramble(cfg_key, g.payload));
						r.taken = 1'b1;
					end else begin
						r.pix = stamp(g.pix, scramble(cfg_key, cfg_marker));
						stego_phase = PH_DONE;
						r.done = 1'b1;
					end
				end
				default: r.done = 1'b1;
			endcase
		end else begin
			plain = unscramble(cfg_key, low_bits(g.pix));
			r.xbyte = plain;
			case (stego_phase)
				PH_START: begin
					if (plain == cfg_marker) stego_phase = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (plain == cfg_marker) begin
						stego_phase = PH_DONE;
						r.done = 1'b1;
					end else begin
						r.xvalid = 1'b1;
					end
				end
				default: r.done = 1'b1;
			endcase
		end
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic logic [7:0] random_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [3:0][7:0] random_pixels();
		logic [3:0][7:0] p;
		for (int k = 0; k < 4; k++) p[k] = random_byte();
		return p;
	endfunction

	function automatic group_t make_group(input logic [3:0][7:0] pix, input logic [7:0] payload,
			input logic pvalid);
		group_t g;
		g.pix = pix;
		g.payload = payload;
		g.pvalid = pvalid;
		return g;
	endfunction

	function automatic group_t embed_group();
		return make_group(random_pixels(), random_byte(), 1'b1);
	endfunction

	// flipping coded bit 7 always changes the plain bit that key entry 0 names
	function automatic group_t extract_group();
		group_t g;
		g = make_group(random_pixels(), random_byte(), 1'($urandom));
		if (unscramble(cfg_key, low_bits(g.pix)) == cfg_marker) g.pix[0][1] = ~g.pix[0][1];
		return g;
	endfunction

	function automatic group_t marker_group();
		return make_group(stamp(random_pixels(), scramble(cfg_key, cfg_marker)), random_byte(),
			1'($urandom));
	endfunction

	function automatic logic [23:0] permutation_key();
		logic [2:0] slot[8];
		logic [2:0] tmp;
		logic [23:0] key;
		int j;
		for (int i = 0; i < 8; i++) slot[i] = 3'(i);
		for (int i = 7; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = slot[i];
			slot[i] = slot[j];
			slot[j] = tmp;
		end
		for (int i = 0; i < 8; i++) key[3 * i +: 3] = slot[i];
		return key;
	endfunction

	function automatic logic [23:0] random_key();
		case ($urandom_range(0, 9))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2, 3: return 24'($urandom);
			default: return permutation_key();
		endcase
	endfunction

	// ---------------- bus tasks ----------------

	task automatic report_mismatch(input string what, input logic [39:0] want,
			input logic [39:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $time);
	endtask

	task automatic send_group(input group_t g);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {g.payload, g.pix};
		s_tuser <= g.pvalid;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_results.push_back(predict_group(g));
		sent++;
	endtask

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic settle();
		@(negedge clk) s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic stream_groups(input int count, input bit ragged);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = ragged ? $urandom_range(1, 12) : count;
			for (int i = 0; i < burst && left > 0; i++) begin
				send_group(cfg_mode == MODE_EMBED ? embed_group() : extract_group());
				left--;
			end
			if (ragged) pause($urandom_range(0, 5));
		end
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		settle();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk) penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MODE:   cfg_mode = val[0];
			REG_KEY:    cfg_key = val[23:0];
			REG_MARKER: cfg_marker = val[7:0];
			default: ;
		endcase
	endtask

	task automatic reg_check(input logic [1:0] idx, input logic [31:0] want);
		settle();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk) penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) report_mismatch("register read", 40'(want), 40'(prdata));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_registers();
		reg_check(REG_MODE, 32'(cfg_mode));
		reg_check(REG_KEY, 32'(cfg_key));
		reg_check(REG_MARKER, 32'(cfg_marker));
	endtask

	// ---------------- tests ----------------

	task automatic test_register_access();
		check_registers();
		reg_write(REG_KEY, 32'hFFFF_FFFF);
		reg_write(REG_MARKER, 32'h0000_0000);
		reg_write(REG_MODE, 32'(MODE_EXTRACT));
		check_registers();
		reg_write(REG_SPARE, 32'hFFFF_FFFF);
		check_registers();
	endtask

	// extract mode before any marker: nothing opens the payload
	task automatic test_extract_search();
		reg_write(REG_KEY, 32'(permutation_key()));
		reg_write(REG_MARKER, 32'hA5);
		send_group(make_group('0, 8'hFF, 1'b1));
		send_group(make_group('1, 8'h00, 1'b0));
		repeat (3) send_group(extract_group());
		reg_write(REG_KEY, 32'h0);
		send_group(make_group('1, 8'h5A, 1'b1));
		reg_write(REG_KEY, 32'o01234566);
		send_group(extract_group());
	endtask

	// first embed group carries the start marker even when payload is offered
	task automatic test_embed_start();
		reg_write(REG_MODE, 32'(MODE_EMBED));
		reg_write(REG_KEY, 32'(KEY_RESET));
		reg_write(REG_MARKER, 32'(MARKER_RESET));
		send_group(make_group(random_pixels(), 8'h3C, 1'b1));
	endtask

	task automatic test_embed_payload();
		send_group(make_group('1, 8'h00, 1'b1));
		send_group(make_group('0, 8'hFF, 1'b1));
		send_group(make_group(random_pixels(), cfg_marker, 1'b1));
		reg_write(REG_KEY, 32'hFF_FFFF);
		send_group(make_group(random_pixels(), 8'h80, 1'b1));
		reg_write(REG_KEY, 32'h0);
		reg_write(REG_MARKER, 32'h0);
		send_group(make_group(random_pixels(), 8'h01, 1'b1));
		send_group(make_group(random_pixels(), 8'h00, 1'b1));
	endtask

	// switch to extract while the payload is open
	task automatic test_extract_payload();
		reg_write(REG_MODE, 32'(MODE_EXTRACT));
		reg_write(REG_KEY, 32'(permutation_key()));
		reg_write(REG_MARKER, 32'h81);
		send_group(make_group('0, 8'h77, 1'b0));
		repeat (3) send_group(extract_group());
	endtask

	task automatic test_random_segments();
		int target;
		target = sent + 1450;
		while (sent < target) begin
			reg_write(REG_MODE, 32'($urandom_range(0, 1) ? MODE_EXTRACT : MODE_EMBED));
			reg_write(REG_KEY, 32'(random_key()));
			reg_write(REG_MARKER, 32'(random_byte()));
			stream_groups($urandom_range(20, 150), $urandom_range(0, 3) != 0);
		end
	endtask

	// payload ends: end marker written, then pass-through
	task automatic test_close();
		reg_write(REG_MODE, 32'(MODE_EMBED));
		reg_write(REG_KEY, 32'(permutation_key()));
		send_group(make_group(random_pixels(), random_byte(), 1'b0));
		repeat (10) begin
			send_group(make_group(random_pixels(), random_byte(), 1'($urandom)));
			pause($urandom_range(0, 2));
		end
	endtask

	task automatic test_done_phase();
		reg_write(REG_MODE, 32'(MODE_EXTRACT));
		reg_write(REG_KEY, 32'(permutation_key()));
		reg_write(REG_MARKER, 32'(random_byte()));
		send_group(marker_group());
		repeat (10) begin
			send_group(extract_group());
			pause($urandom_range(0, 2));
		end
	endtask

	// ---------------- checking, receiver, watchdog ----------------

	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result beat", '0, m_tdata);
			end else begin
				want = expected_results.pop_front();
				for (int k = 0; k < 4; k++)
					if (m_tdata[8 * k +: 8] !== want.pix[k])
						report_mismatch($sformatf("pixel_out_%0d", k), 40'(want.pix[k]),
							40'(m_tdata[8 * k +: 8]));
				if (m_tdata[39:32] !== want.xbyte)
					report_mismatch("extracted_byte", 40'(want.xbyte), 40'(m_tdata[39:32]));
				if (m_tuser[0] !== want.taken)
					report_mismatch("payload_taken", 40'(want.taken), 40'(m_tuser[0]));
				if (m_tuser[1] !== want.xvalid)
					report_mismatch("extracted_valid", 40'(want.xvalid), 40'(m_tuser[1]));
				if (m_tuser[2] !== want.done)
					report_mismatch("done_res", 40'(want.done), 40'(m_tuser[2]));
			end
		end
	end

	always @(negedge clk) begin
		rx_count <= rx_count + 1;
		if (rx_count % 97 == 0) rx_style <= rx_style_t'($urandom_range(0, 3));
		case (rx_style)
			RX_OPEN:  m_tready <= 1'b1;
			RX_COIN:  m_tready <= 1'($urandom);
			RX_COMB:  m_tready <= (rx_count % 4) != 0;
			RX_CHOKE: m_tready <= $urandom_range(0, 3) == 0;
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_register_access();
		test_extract_search();
		test_embed_start();
		test_embed_payload();
		test_extract_payload();
		test_random_segments();
		test_close();
		test_done_phase();

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: lsb_stego_embed_extract.f
rtl/lsbse_pkg.sv
rtl/lsbse_core.sv
rtl/lsb_stego_embed_extract.sv
sim/testbench.sv
